// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- src/pps_pkg.sv -----
`timescale 1ns / 1ps

package pps_pkg;

   localparam int SLOTS   = 16;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ID_W    = 8;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 32;

   // operation codes on req_op
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_ARRIVE = 1'b1;

   // result kinds on rsp_kind
   localparam logic KIND_DONE   = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   // record that moves one cell down the chain each cycle
   typedef struct packed {
      logic                active;
      logic                op;
      logic [ID_W-1:0]     task_id;
      logic [BURST_W-1:0]  burst_len;
      logic [PRIO_W-1:0]   prio_level;
      logic                found;
      logic [IDX_W-1:0]    best_idx;
      logic [PRIO_W-1:0]   best_prio;
      logic [BURST_W-1:0]  best_rem;
      logic [ID_W-1:0]     best_task;
      logic [TIME_W-1:0]   best_arr;
      logic [TIME_W-1:0]   best_due;
   } wave_type;

   // update broadcast to all cells once a tick has chosen its task
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             retire;
   } commit_type;

endpackage

// ----- src/preemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// a result is registered from the record that leaves the tail of the slot cells
// one item in flight at a time; req_ready is high only in ST_IDLE
// a result waiting on rsp_ready holds the next item that needs a result in ST_FINISH
// reset: tick counter zero, all slots free, no item in flight, no result pending

`include "assert_macros.svh"

module preemptive_priority_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [pps_pkg::ID_W-1:0]        req_task_id,
   input  logic [pps_pkg::BURST_W-1:0]     req_burst_len,
   input  logic [pps_pkg::PRIO_W-1:0]      req_prio_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [pps_pkg::ID_W-1:0]        rsp_done_id,
   output logic [pps_pkg::TIME_W-1:0]      rsp_wait_time,
   output logic [pps_pkg::TIME_W-1:0]      rsp_turnaround_time
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   logic [pps_pkg::TIME_W-1:0]      tick_ff, tick_in;
   pps_pkg::wave_type               rec_ff, rec_in;
   pps_pkg::wave_type               inject;
   pps_pkg::wave_type               wave_link [pps_pkg::SLOTS+1];
   pps_pkg::commit_type             commit;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            kind_ff, kind_in;
   logic [pps_pkg::ID_W-1:0]        id_ff, id_in;
   logic [pps_pkg::TIME_W-1:0]      wait_ff, wait_in;
   logic [pps_pkg::TIME_W-1:0]      turn_ff, turn_in;

   logic                            accept, is_tick, retire, need_rsp, leave;
   logic [pps_pkg::TIME_W-1:0]      finish;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // record entering the head of the chain
   always_comb begin
      inject            = '0;
      inject.active     = accept;
      inject.op         = req_op;
      inject.task_id    = req_task_id;
      inject.burst_len  = req_burst_len;
      inject.prio_level = req_prio_level;
   end

   assign wave_link[0] = inject;

   // row of slot cells
   for (genvar i = 0; i < pps_pkg::SLOTS; i++) begin : g_cell
      pps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .slot_idx   (pps_pkg::IDX_W'(i)),
         .tick_count (tick_ff),
         .commit     (commit),
         .wave_up    (wave_link[i]),
         .wave_dn    (wave_link[i+1])
      );
   end

   // decisions on the record that left the tail
   assign is_tick  = (rec_ff.op == pps_pkg::OP_TICK);
   assign retire   = (rec_ff.best_rem <= pps_pkg::BURST_W'(1));
   assign need_rsp = is_tick ? (rec_ff.found && retire) : !rec_ff.found;
   assign leave    = (state_ff == ST_FINISH) && (!need_rsp || !rsp_valid_ff || rsp_ready);
   assign finish   = tick_ff + pps_pkg::TIME_W'(1);

   always_comb begin
      commit.en     = leave && is_tick && rec_ff.found;
      commit.idx    = rec_ff.best_idx;
      commit.retire = retire;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      rec_in   = rec_ff;
      tick_in  = tick_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (wave_link[pps_pkg::SLOTS].active) begin
               rec_in   = wave_link[pps_pkg::SLOTS];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (leave) begin
               state_in = ST_IDLE;
               if (is_tick) begin
                  tick_in = finish;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      wait_in      = wait_ff;
      turn_in      = turn_ff;
      if (leave && need_rsp) begin
         rsp_valid_in = 1'b1;
         if (is_tick) begin
            kind_in = pps_pkg::KIND_DONE;
            id_in   = rec_ff.best_task;
            wait_in = finish - rec_ff.best_due;
            turn_in = finish - rec_ff.best_arr;
         end else begin
            kind_in = pps_pkg::KIND_REJECT;
            id_in   = rec_ff.task_id;
            wait_in = '0;
            turn_in = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      kind_ff <= kind_in;
      id_ff   <= id_in;
      wait_ff <= wait_in;
      turn_ff <= turn_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_done_id         = id_ff;
   assign rsp_wait_time       = wait_ff;
   assign rsp_turnaround_time = turn_ff;

   // checks
   `ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == ST_SCAN)
   `ASSERT_SAME(a_tail_only_in_scan, clock, reset, wave_link[pps_pkg::SLOTS].active,
                state_ff == ST_SCAN)
   `ASSERT_SAME(a_commit_in_finish, clock, reset, commit.en,
                state_ff == ST_FINISH && is_tick && rec_ff.found)
   `ASSERT_NEXT(a_tick_advances, clock, reset, leave && is_tick,
                tick_ff == $past(tick_ff) + pps_pkg::TIME_W'(1))

endmodule

// ----- src/pps_cell.sv -----
`timescale 1ns / 1ps

module pps_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pps_pkg::IDX_W-1:0]         slot_idx,
   input  logic [pps_pkg::TIME_W-1:0]        tick_count,
   input  pps_pkg::commit_type               commit,
   input  pps_pkg::wave_type                 wave_up,
   output pps_pkg::wave_type                 wave_dn
);

   logic                           valid_ff, valid_in;
   logic [pps_pkg::ID_W-1:0]       task_ff;
   logic [pps_pkg::BURST_W-1:0]    rem_ff;
   logic [pps_pkg::PRIO_W-1:0]     prio_ff;
   logic [pps_pkg::TIME_W-1:0]     arr_ff;
   logic [pps_pkg::TIME_W-1:0]     due_ff;
   pps_pkg::wave_type              wave_ff, wave_in;

   logic claim, beats, take, hit;

   // arrival takes the first free cell it passes
   assign claim = wave_up.active && (wave_up.op == pps_pkg::OP_ARRIVE) &&
                  !wave_up.found && !valid_ff;

   // lower priority number wins, then smaller remaining; equal keeps upstream slot
   assign beats = (prio_ff < wave_up.best_prio) ||
                  ((prio_ff == wave_up.best_prio) && (rem_ff < wave_up.best_rem));

   assign take = wave_up.active && (wave_up.op == pps_pkg::OP_TICK) && valid_ff &&
                 (!wave_up.found || beats);

   assign hit = commit.en && (commit.idx == slot_idx);

   // record handed to the next cell
   always_comb begin
      wave_in = wave_up;
      if (claim) begin
         wave_in.found = 1'b1;
      end
      if (take) begin
         wave_in.found     = 1'b1;
         wave_in.best_idx  = slot_idx;
         wave_in.best_prio = prio_ff;
         wave_in.best_rem  = rem_ff;
         wave_in.best_task = task_ff;
         wave_in.best_arr  = arr_ff;
         wave_in.best_due  = due_ff;
      end
   end

   // occupancy of this slot
   always_comb begin
      valid_in = valid_ff;
      if (claim) begin
         valid_in = 1'b1;
      end else if (hit && commit.retire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in;
      end
   end

   // slot contents, written on claim, counted down on service
   always_ff @(posedge clock) begin
      if (claim) begin
         task_ff <= wave_up.task_id;
         rem_ff  <= wave_up.burst_len;
         prio_ff <= wave_up.prio_level;
         arr_ff  <= tick_count;
         due_ff  <= tick_count + pps_pkg::TIME_W'(wave_up.burst_len);
      end else if (hit && !commit.retire) begin
         rem_ff  <= rem_ff - pps_pkg::BURST_W'(1);
      end
   end

   assign wave_dn = wave_ff;

endmodule
